@@ rtl/fsum_pkg.sv @@
// Shared constants and types for the packet checksum trailer block.
package fsum_pkg;

    localparam int SYNC_BYTES  = 4;
    localparam int PRIM_OFFSET = 10;

    localparam int POS_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int WSUM_W  = 16;
    localparam int TRL_BEATS = 4;
    localparam int TRL_CNT_W = $clog2(TRL_BEATS + 1);

    localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};
    localparam logic [POS_W-1:0]  SYNC_POS = POS_W'(SYNC_BYTES);
    localparam logic [POS_W-1:0]  PRIM_POS = POS_W'(PRIM_OFFSET);
    localparam logic [BYTE_W:0]   MOD_BASE = 9'd255;

    // Checksum bytes captured with the final data byte
    typedef struct packed {
        logic [BYTE_W-1:0] simple;
        logic [BYTE_W-1:0] fletcher;
        logic [WSUM_W-1:0] wrapping;
    } trl_t;

endpackage

@@ rtl/fsum_accum.sv @@
// Running simple, Fletcher and wrapping sums with the byte position counter.
module fsum_accum (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [fsum_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          last_byte,
    output fsum_pkg::trl_t                trl
);

    logic [fsum_pkg::POS_W-1:0]  pos_reg,      pos_next;
    logic [fsum_pkg::BYTE_W-1:0] simple_reg,   simple_next;
    logic [fsum_pkg::BYTE_W-1:0] fletcher_reg, fletcher_next;
    logic [fsum_pkg::WSUM_W-1:0] wrap_reg,     wrap_next;

    logic [fsum_pkg::POS_W-1:0]  pos_p1, pos_p2;
    logic [fsum_pkg::BYTE_W-1:0] s_upd, f_upd;
    logic [fsum_pkg::WSUM_W-1:0] w_upd, w_fin;

    function automatic logic [fsum_pkg::BYTE_W-1:0] mod255_add(
        input logic [fsum_pkg::BYTE_W-1:0] a,
        input logic [fsum_pkg::BYTE_W-1:0] b
    );
        logic [fsum_pkg::BYTE_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= fsum_pkg::MOD_BASE) begin
            sum = sum - fsum_pkg::MOD_BASE;
        end
        return sum[fsum_pkg::BYTE_W-1:0];
    endfunction

    function automatic logic [fsum_pkg::POS_W-1:0] sat_inc(
        input logic [fsum_pkg::POS_W-1:0] p
    );
        return (p == fsum_pkg::POS_MAX) ? p : p + 1'b1;
    endfunction

    always_comb begin
        pos_p1 = sat_inc(pos_reg);
        pos_p2 = sat_inc(pos_p1);

        s_upd = simple_reg;
        f_upd = fletcher_reg;
        if (pos_reg >= fsum_pkg::PRIM_POS) begin
            s_upd = mod255_add(simple_reg, data_byte);
            f_upd = mod255_add(fletcher_reg, s_upd);
        end

        w_upd = wrap_reg;
        if (pos_reg >= fsum_pkg::SYNC_POS) begin
            w_upd = wrap_reg + fsum_pkg::WSUM_W'(data_byte);
        end

        // Fletcher trailer bytes sit at the two offsets after the final byte
        w_fin = w_upd;
        if (pos_p1 >= fsum_pkg::SYNC_POS) begin
            w_fin = w_fin + fsum_pkg::WSUM_W'(s_upd);
        end
        if (pos_p2 >= fsum_pkg::SYNC_POS) begin
            w_fin = w_fin + fsum_pkg::WSUM_W'(f_upd);
        end

        trl.simple   = s_upd;
        trl.fletcher = f_upd;
        trl.wrapping = w_fin;

        pos_next      = pos_reg;
        simple_next   = simple_reg;
        fletcher_next = fletcher_reg;
        wrap_next     = wrap_reg;
        if (accept) begin
            if (last_byte) begin
                pos_next      = '0;
                simple_next   = '0;
                fletcher_next = '0;
                wrap_next     = '0;
            end else begin
                pos_next      = pos_p1;
                simple_next   = s_upd;
                fletcher_next = f_upd;
                wrap_next     = w_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            simple_reg   <= '0;
            fletcher_reg <= '0;
            wrap_reg     <= '0;
        end else begin
            pos_reg      <= pos_next;
            simple_reg   <= simple_next;
            fletcher_reg <= fletcher_next;
            wrap_reg     <= wrap_next;
        end
    end

    a_simple_range: assert property (@(posedge aclk) disable iff (!aresetn)
        simple_reg != 8'hFF && fletcher_reg != 8'hFF)
        else $error("mod-255 sum left its range");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && last_byte |=> pos_reg == '0 && wrap_reg == '0 && simple_reg == '0)
        else $error("sums not cleared after final byte");

endmodule

@@ rtl/fsum_out.sv @@
// Output register and trailer sequencer for pass-through and checksum beats.
module fsum_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fsum_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          last_byte,
    input  fsum_pkg::trl_t                trl,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fsum_pkg::BYTE_W-1:0]   m_out_byte,
    output logic                          m_is_trailer,
    output logic                          m_end_of_packet
);

    localparam int SHIFT_W = fsum_pkg::TRL_BEATS * fsum_pkg::BYTE_W;

    logic                              valid_reg,   valid_next;
    logic [fsum_pkg::BYTE_W-1:0]       byte_reg,    byte_next;
    logic                              trailer_reg, trailer_next;
    logic                              eop_reg,     eop_next;
    logic [fsum_pkg::TRL_CNT_W-1:0]    left_reg,    left_next;
    logic [SHIFT_W-1:0]                shift_reg,   shift_next;
    logic                              slot_free;
    logic                              accept;

    assign slot_free = !valid_reg || m_ready;
    assign s_ready   = slot_free && (left_reg == '0);
    assign accept    = s_valid && s_ready;

    always_comb begin
        valid_next   = valid_reg;
        byte_next    = byte_reg;
        trailer_next = trailer_reg;
        eop_next     = eop_reg;
        left_next    = left_reg;
        shift_next   = shift_reg;
        if (accept) begin
            valid_next   = 1'b1;
            byte_next    = data_byte;
            trailer_next = 1'b0;
            eop_next     = 1'b0;
            if (last_byte) begin
                left_next  = fsum_pkg::TRL_CNT_W'(fsum_pkg::TRL_BEATS);
                shift_next = {trl.simple, trl.fletcher, trl.wrapping};
            end
        end else if (left_reg != '0 && slot_free) begin
            // Advance one checksum beat
            valid_next   = 1'b1;
            byte_next    = shift_reg[SHIFT_W-1 -: fsum_pkg::BYTE_W];
            trailer_next = 1'b1;
            eop_next     = (left_reg == fsum_pkg::TRL_CNT_W'(1));
            left_next    = left_reg - 1'b1;
            shift_next   = {shift_reg[SHIFT_W-fsum_pkg::BYTE_W-1:0],
                            {fsum_pkg::BYTE_W{1'b0}}};
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            left_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
        byte_reg    <= byte_next;
        trailer_reg <= trailer_next;
        eop_reg     <= eop_next;
        shift_reg   <= shift_next;
    end

    assign m_valid         = valid_reg;
    assign m_out_byte      = byte_reg;
    assign m_is_trailer    = trailer_reg;
    assign m_end_of_packet = eop_reg;

    a_eop_is_trailer: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && eop_reg |-> trailer_reg && left_reg == '0)
        else $error("end of packet outside the trailer");

    a_trailer_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && trailer_reg && !eop_reg |-> left_reg != '0)
        else $error("trailer ended before its last beat");

    a_last_starts_trailer: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && last_byte |=> left_reg == fsum_pkg::TRL_CNT_W'(fsum_pkg::TRL_BEATS)
                               && valid_reg && !trailer_reg)
        else $error("final byte did not start the trailer");

endmodule

@@ rtl/packet_fletcher_sum_trailer.sv @@
// Packet checksum trailer generator: top level.
// Bytes pass through the output register one per cycle while the output is
// not stalled and no trailer is going out; a byte is taken in the same cycle
// that the previous beat leaves. After the beat flagged last, four checksum
// beats follow (simple, Fletcher, wrapping sum high, wrapping sum low) and the
// input is held off until those four beats have gone out. The output register
// sets the rate: one beat per cycle on the result side while m_ready is high.
module packet_fletcher_sum_trailer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fsum_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic                          s_last_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fsum_pkg::BYTE_W-1:0]   m_out_byte,
    output logic                          m_is_trailer,
    output logic                          m_end_of_packet
);

    fsum_pkg::trl_t trl;
    logic           accept;

    assign accept = s_valid && s_ready;

    fsum_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .trl       (trl)
    );

    fsum_out u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .data_byte       (s_data_byte),
        .last_byte       (s_last_byte),
        .trl             (trl),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_is_trailer    (m_is_trailer),
        .m_end_of_packet (m_end_of_packet)
    );

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the packet checksum trailer block.
module tb;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int LONG_HOLD       = 80;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_BEATS    = 45;
    localparam int CALM_BEATS      = 25;

    typedef struct packed {
        logic [fsum_pkg::BYTE_W-1:0] out_byte;
        logic                        is_trailer;
        logic                        end_of_packet;
    } beat_t;

    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        s_valid     = 1'b0;
    logic                        s_ready;
    logic [fsum_pkg::BYTE_W-1:0] s_data_byte = '0;
    logic                        s_last_byte = 1'b0;
    logic                        m_valid;
    logic                        m_ready     = 1'b0;
    logic [fsum_pkg::BYTE_W-1:0] m_out_byte;
    logic                        m_is_trailer;
    logic                        m_end_of_packet;

    // Predicted packet state
    logic [fsum_pkg::POS_W-1:0]  run_pos      = '0;
    logic [fsum_pkg::BYTE_W-1:0] run_simple   = '0;
    logic [fsum_pkg::BYTE_W-1:0] run_fletcher = '0;
    logic [fsum_pkg::WSUM_W-1:0] run_wrap     = '0;

    beat_t pending_beats[$];

    int  mismatches   = 0;
    int  beats_in     = 0;
    int  beats_out    = 0;
    int  packets_sent = 0;
    int  quiet_cycles = 0;
    bit  tx_idle_on   = 1'b1;
    bit  rx_idle_on   = 1'b1;
    bit  hold_req     = 1'b0;
    bit  holding      = 1'b0;

    packet_fletcher_sum_trailer dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_is_trailer    (m_is_trailer),
        .m_end_of_packet (m_end_of_packet)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic logic [fsum_pkg::POS_W-1:0] sat_next(logic [fsum_pkg::POS_W-1:0] p);
        return (p == fsum_pkg::POS_MAX) ? p : p + 1'b1;
    endfunction

    function automatic void add_past_sync(logic [fsum_pkg::POS_W-1:0] p,
                                          logic [fsum_pkg::BYTE_W-1:0] v);
        if (p >= fsum_pkg::SYNC_POS) begin
            run_wrap = run_wrap + fsum_pkg::WSUM_W'(v);
        end
    endfunction

    function automatic void push_beat(logic [fsum_pkg::BYTE_W-1:0] v, logic trl, logic eop);
        beat_t bt;
        bt.out_byte      = v;
        bt.is_trailer    = trl;
        bt.end_of_packet = eop;
        pending_beats.push_back(bt);
    endfunction

    // Work out the beats that one accepted packet byte produces
    function automatic void predict_checksum_beats(logic [fsum_pkg::BYTE_W-1:0] b, logic last);
        logic [fsum_pkg::POS_W-1:0] p1;
        logic [fsum_pkg::POS_W-1:0] p2;
        push_beat(b, 1'b0, 1'b0);
        if (run_pos >= fsum_pkg::PRIM_POS) begin
            run_simple   = fsum_pkg::BYTE_W'((int'(run_simple) + int'(b))
                                             % int'(fsum_pkg::MOD_BASE));
            run_fletcher = fsum_pkg::BYTE_W'((int'(run_fletcher) + int'(run_simple))
                                             % int'(fsum_pkg::MOD_BASE));
        end
        add_past_sync(run_pos, b);
        if (!last) begin
            run_pos = sat_next(run_pos);
        end else begin
            // the two Fletcher trailer bytes sit at the next two offsets
            p1 = sat_next(run_pos);
            p2 = sat_next(p1);
            add_past_sync(p1, run_simple);
            add_past_sync(p2, run_fletcher);
            push_beat(run_simple, 1'b1, 1'b0);
            push_beat(run_fletcher, 1'b1, 1'b0);
            push_beat(run_wrap[fsum_pkg::WSUM_W-1:fsum_pkg::BYTE_W], 1'b1, 1'b0);
            push_beat(run_wrap[fsum_pkg::BYTE_W-1:0], 1'b1, 1'b1);
            run_pos      = '0;
            run_simple   = '0;
            run_fletcher = '0;
            run_wrap     = '0;
        end
    endfunction

    function automatic void compare_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_result_beat();
        beat_t want;
        beats_out++;
        if (pending_beats.size() == 0) begin
            $error("unexpected result beat: out_byte %0d", m_out_byte);
            mismatches++;
        end else begin
            want = pending_beats.pop_front();
            compare_field("out_byte", want.out_byte, m_out_byte);
            compare_field("is_trailer", want.is_trailer, m_is_trailer);
            compare_field("end_of_packet", want.end_of_packet, m_end_of_packet);
        end
    endfunction

    // Predict on input beats, check output beats, watch for a hang
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_checksum_beats(s_data_byte, s_last_byte);
            end
            if (m_valid && m_ready) begin
                check_result_beat();
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("tb failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, quiet stretches, and one long hold on request
    always begin
        @(posedge aclk);
        if (hold_req) begin
            hold_req = 1'b0;
            holding  = 1'b1;
            m_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge aclk);
            holding  = 1'b0;
            m_ready <= 1'b1;
        end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b1;
            repeat ($urandom_range(0, 19)) @(posedge aclk);
        end
    end

    function automatic logic [fsum_pkg::BYTE_W-1:0] random_byte();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            return '1;
        end else if (pick == 1) begin
            return '0;
        end
        return fsum_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    // Offer one beat and hold it until taken; valid stays high for the next call
    task automatic send_byte(input logic [fsum_pkg::BYTE_W-1:0] b, input logic last);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        beats_in++;
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_packet(input logic [fsum_pkg::BYTE_W-1:0] pkt[$]);
        for (int i = 0; i < pkt.size(); i++) begin
            send_byte(pkt[i], i == pkt.size() - 1);
        end
        packets_sent++;
    endtask

    task automatic send_random_packet(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(random_byte(), i == len - 1);
        end
        packets_sent++;
    endtask

    // Short packets that end before and around the sum start offsets, extreme bytes
    task automatic test_directed();
        logic [fsum_pkg::BYTE_W-1:0] pkt[$];
        pkt = '{8'hFF};
        send_packet(pkt);
        pkt = '{8'h00, 8'hFF, 8'hFF};
        send_packet(pkt);
        pkt = '{8'hEB, 8'h90, 8'h00, 8'hFF, 8'h01};
        send_packet(pkt);
        // all-ones bytes land exactly on the modulus
        pkt.delete();
        for (int i = 0; i < fsum_pkg::PRIM_OFFSET + 2; i++) begin
            pkt.push_back(8'hFF);
        end
        send_packet(pkt);
        stop_sending();
    endtask

    // Hold the output off for a long stretch while input keeps coming
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        hold_req   = 1'b1;
        while (!holding) @(posedge aclk);
        send_random_packet(24);
        tx_idle_on = 1'b1;
        stop_sending();
    endtask

    function automatic int random_length();
        if ($urandom_range(0, 9) < 3) begin
            return $urandom_range(1, fsum_pkg::PRIM_OFFSET + 2);
        end
        return $urandom_range(1, 24);
    endfunction

    task automatic test_random_packets();
        int goal;
        goal = beats_in + RANDOM_BEATS;
        while (beats_in < goal) begin
            send_random_packet(random_length());
        end
        stop_sending();
    endtask

    // Full-rate traffic on both sides to finish
    task automatic test_full_rate();
        int goal;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        goal = beats_in + CALM_BEATS;
        while (beats_in < goal) begin
            send_random_packet(random_length());
        end
        stop_sending();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random_packets();
        test_full_rate();
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d packets, %0d input beats, %0d output beats checked",
                 packets_sent, beats_in, beats_out);
        $display("covered short packets, all-ones bytes, random lengths and a long output stall");
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/fsum_pkg.sv
rtl/fsum_accum.sv
rtl/fsum_out.sv
rtl/packet_fletcher_sum_trailer.sv
tb/sv/tb.sv
